// ----- rtl/scps_pkg.sv -----
// ============================================================================
// Scene cut peak suppression package
// Shared widths, constants and the job record passed from selection to output.
// ============================================================================
package scps_pkg;

    // Store geometry
    localparam int MAX_DISTANCES = 32;
    localparam int DISTANCE_BITS = 16;
    localparam int IDX_W         = (MAX_DISTANCES > 1) ? $clog2(MAX_DISTANCES) : 1;
    localparam int CNT_W         = $clog2(MAX_DISTANCES + 1);

    // Configuration register
    localparam int              RADIUS_W     = 6;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd4;

    // Window arithmetic width: a count plus a radius without overflow
    localparam int SUM_W = ((CNT_W > RADIUS_W) ? CNT_W : RADIUS_W) + 1;

    // Result fields
    localparam int SCENE_W = 6;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = ((DISTANCE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * SCENE_W + 7) / 8) * 8;

    // Job queue between selection and output
    localparam int JOB_DEPTH = 2;
    localparam int JQ_PTR_W  = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JQ_CNT_W  = $clog2(JOB_DEPTH + 1);

    // One finished set: which store entries were chosen as cuts, and how many
    // entries the set holds.
    typedef struct packed {
        logic [MAX_DISTANCES-1:0] cut_mask;
        logic [CNT_W-1:0]         count;
    } scps_job_t;

endpackage

// ----- rtl/scps_front.sv -----
// ============================================================================
// Scene cut front end
// Loads distances into the store and runs the greedy peak selection over it.
// ============================================================================
module scps_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [scps_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           cfg_wr_en,
    input  logic [scps_pkg::RADIUS_W-1:0]  cfg_wr_data,
    output logic                           job_valid,
    input  logic                           job_ready,
    output scps_pkg::scps_job_t            job
);
    import scps_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_APPLY,
        ST_PUSH
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]           issue_reg, issue_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]           rd_idx_reg, rd_idx_next;
    logic                       found_reg, found_next;
    logic [IDX_W-1:0]           best_reg, best_next;
    logic [DISTANCE_BITS-1:0]   best_val_reg, best_val_next;
    logic [MAX_DISTANCES-1:0]   excl_reg, excl_next;
    logic [MAX_DISTANCES-1:0]   chosen_reg, chosen_next;
    logic [RADIUS_W-1:0]        radius_reg;
    logic [DISTANCE_BITS-1:0]   rd_data_reg;
    logic [DISTANCE_BITS-1:0]   mem [MAX_DISTANCES];

    logic                       accept;
    logic                       store_wr;
    logic                       blocked;
    logic [SUM_W-1:0]           best_w;
    logic [SUM_W-1:0]           radius_w;
    logic [SUM_W-1:0]           cnt_w;
    logic [SUM_W-1:0]           win_lo;
    logic [SUM_W-1:0]           win_hi_raw;
    logic [SUM_W-1:0]           win_hi;
    logic [MAX_DISTANCES-1:0]   win_mask;

    assign s_tready      = (state_reg == ST_LOAD);
    assign accept        = s_tvalid && s_tready;
    assign store_wr      = accept && (load_cnt_reg < CNT_W'(MAX_DISTANCES));
    assign job_valid     = (state_reg == ST_PUSH);
    assign job.cut_mask  = chosen_reg;
    assign job.count     = load_cnt_reg;

    // Exclusion radius register: the user writes it only while idle; not enforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_wr_en) begin
            radius_reg <= cfg_wr_data;
        end
    end

    // Distance store: one write per loaded item, one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            mem[load_cnt_reg[IDX_W-1:0]] <= s_tdata[DISTANCE_BITS-1:0];
        end
        rd_data_reg <= mem[issue_reg[IDX_W-1:0]];
    end

    // An entry already chosen or inside an earlier window takes no part.
    assign blocked = excl_reg[rd_idx_reg] | chosen_reg[rd_idx_reg];

    // Suppression window around the current pick, clamped to [0, count).
    assign best_w     = SUM_W'(best_reg);
    assign radius_w   = SUM_W'(radius_reg);
    assign cnt_w      = SUM_W'(load_cnt_reg);
    assign win_lo     = (best_w > radius_w) ? (best_w - radius_w) : '0;
    assign win_hi_raw = best_w + radius_w;
    assign win_hi     = (win_hi_raw > cnt_w) ? cnt_w : win_hi_raw;

    always_comb begin
        for (int k = 0; k < MAX_DISTANCES; k++) begin
            win_mask[k] = (SUM_W'(k) >= win_lo) && (SUM_W'(k) < win_hi);
        end
    end

    // Load, scan for the largest free entry, apply the pick, hand off the set.
    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        issue_next    = issue_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = issue_reg[IDX_W-1:0];
        found_next    = found_reg;
        best_next     = best_reg;
        best_val_next = best_val_reg;
        excl_next     = excl_reg;
        chosen_next   = chosen_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (store_wr) begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        state_next    = ST_SCAN;
                        excl_next     = '0;
                        chosen_next   = '0;
                        issue_next    = '0;
                        found_next    = 1'b0;
                        best_val_next = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_reg < load_cnt_reg) begin
                    issue_next  = issue_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                // Strict compare in ascending order keeps the lower index on ties.
                if (rd_vld_reg && !blocked && (!found_reg || rd_data_reg > best_val_reg)) begin
                    found_next    = 1'b1;
                    best_next     = rd_idx_reg;
                    best_val_next = rd_data_reg;
                end
                if ((issue_reg == load_cnt_reg) && !rd_vld_reg) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (found_reg) begin
                    chosen_next   = chosen_reg | (MAX_DISTANCES'(1) << best_reg);
                    excl_next     = excl_reg | win_mask;
                    issue_next    = '0;
                    found_next    = 1'b0;
                    best_val_next = '0;
                    state_next    = ST_SCAN;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (job_ready) begin
                    load_cnt_next = '0;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State and registered values of the selection engine.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            found_reg    <= found_next;
        end
        rd_idx_reg   <= rd_idx_next;
        best_reg     <= best_next;
        best_val_reg <= best_val_next;
        excl_reg     <= excl_next;
        chosen_reg   <= chosen_next;
    end

    // A pick is never an entry that was already chosen or excluded.
    a_pick_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) && found_reg |-> !excl_reg[best_reg] && !chosen_reg[best_reg])
        else $error("front: picked an entry that was not free");

    // Each applied pick adds exactly one cut.
    a_one_cut: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_APPLY) && found_reg
        |=> $countones(chosen_reg) == $past($countones(chosen_reg)) + 1)
        else $error("front: cut mask did not grow by one");

endmodule

// ----- rtl/scps_job_fifo.sv -----
// ============================================================================
// Scene cut job queue
// Short queue of finished selections between the front end and the output.
// ============================================================================
module scps_job_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  scps_pkg::scps_job_t in_job,
    output logic                out_valid,
    input  logic                out_ready,
    output scps_pkg::scps_job_t out_job
);
    import scps_pkg::*;

    scps_job_t           slot [JOB_DEPTH];
    logic [JQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JQ_CNT_W-1:0] count_reg, count_next;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg < JQ_CNT_W'(JOB_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = slot[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == JQ_PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == JQ_PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot[wr_ptr_reg] <= in_job;
        end
    end

    // An empty queue has its pointers together.
    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("job queue: empty with pointers apart");

endmodule

// ----- rtl/scps_back.sv -----
// ============================================================================
// Scene cut back end
// Walks a finished cut mask in ascending order and emits one item per scene.
// ============================================================================
module scps_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  scps_pkg::scps_job_t            job,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [scps_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);
    import scps_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t                   state_reg, state_next;
    logic [MAX_DISTANCES-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         prev_reg, prev_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [SCENE_W-1:0]       start_reg, start_next;
    logic [SCENE_W-1:0]       end_reg, end_next;
    logic                     m_tlast_reg, m_tlast_next;
    logic                     slot_free;
    logic [CNT_W-1:0]         idx_inc;
    logic [CNT_W:0]           final_end;

    assign job_ready = (state_reg == ST_IDLE);
    assign slot_free = !m_tvalid_reg || m_tready;
    assign idx_inc   = idx_reg + 1'b1;
    assign final_end = {1'b0, cnt_reg} + 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = M_TDATA_W'({end_reg, start_reg});

    // One store position per cycle; a cut waits until the output register is free.
    always_comb begin
        state_next    = state_reg;
        mask_next     = mask_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        prev_next     = prev_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        start_next    = start_reg;
        end_next      = end_reg;
        m_tlast_next  = m_tlast_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    mask_next  = job.cut_mask;
                    cnt_next   = job.count;
                    idx_next   = '0;
                    prev_next  = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (idx_reg < cnt_reg) begin
                    if (mask_reg[idx_reg[IDX_W-1:0]]) begin
                        if (slot_free) begin
                            m_tvalid_next = 1'b1;
                            start_next    = SCENE_W'(prev_reg);
                            end_next      = SCENE_W'(idx_inc);
                            m_tlast_next  = 1'b0;
                            prev_next     = idx_inc;
                            idx_next      = idx_inc;
                        end
                    end else begin
                        idx_next = idx_inc;
                    end
                end else if (slot_free) begin
                    // Closing scene runs to one past the count.
                    m_tvalid_next = 1'b1;
                    start_next    = SCENE_W'(prev_reg);
                    end_next      = SCENE_W'(final_end);
                    m_tlast_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, walk position and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        mask_reg    <= mask_next;
        cnt_reg     <= cnt_next;
        idx_reg     <= idx_next;
        prev_reg    <= prev_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        m_tlast_reg <= m_tlast_next;
    end

    // Every scene is non-empty.
    a_scene_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (start_reg < end_reg))
        else $error("back: scene start not below scene end");

    // The walk never runs past the set.
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (idx_reg <= cnt_reg) && (prev_reg <= idx_reg))
        else $error("back: walk position out of range");

endmodule

// ----- rtl/scene_cut_peak_suppression_core.sv -----
// ============================================================================
// Scene cut peak suppression core
// Turns a set of frame distances into scene boundaries by greedy 1-D
// non-maximum suppression, then streams the scenes in ascending order.
// ============================================================================
//
//  Channel   Direction  Item contents (tdata low bits first)       Marker
//  s_        in         distance [15:0]                            tlast = last distance
//  m_        out        scene_start [5:0], scene_end [11:6]        tlast = last scene
//  cfg_      in         exclusion_radius [5:0]                     write enable, no reply
//
// Distances load at one item per cycle while s_tready is high. After the last item the
// selection scans the store once per pick and once more to find no free entry, and the
// input stays stalled until the finished set is taken by the job queue. The scene walk
// steps through the stored positions, waits on output stalls and overlaps the next
// set's loading through a two-deep job queue.
// Reset is synchronous on aresetn low and empties the store count and queue.
module scene_cut_peak_suppression_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [scps_pkg::S_TDATA_W-1:0] s_tdata,    // distance
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [scps_pkg::M_TDATA_W-1:0] m_tdata,    // scene_start, scene_end
    output logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [scps_pkg::RADIUS_W-1:0]  cfg_wr_data
);
    import scps_pkg::*;

    logic      fr_valid;
    logic      fr_ready;
    scps_job_t fr_job;
    logic      bk_valid;
    logic      bk_ready;
    scps_job_t bk_job;

    // Loading and selection.
    scps_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .job_valid   (fr_valid),
        .job_ready   (fr_ready),
        .job         (fr_job)
    );

    // Finished sets waiting for output.
    scps_job_fifo u_job_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_job    (fr_job),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_job   (bk_job)
    );

    // Scene output.
    scps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (bk_valid),
        .job_ready (bk_ready),
        .job       (bk_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ----- dv/scene_cut_peak_suppression_core_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Scene cut peak suppression core testbench
// Streams sets of frame distances into the core under several exclusion radii
// and checks every scene item against a greedy suppression predictor. The
// sender runs in random bursts in the random sets, and the receiver stalls on its own pattern.
// ============================================================================
module scene_cut_peak_suppression_core_tb;

    import scps_pkg::*;

    localparam int ITEM_TARGET  = 320;
    localparam int SETTLE_CYC   = 64;
    localparam int IDLE_LIMIT   = 400000;

    // One expected scene item.
    typedef struct {
        logic [SCENE_W-1:0] first_frame;
        logic [SCENE_W-1:0] cut_pos;
        logic               final_scene;
    } scene_t;

    typedef enum int {RX_FULL_RATE, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;   // distance
    logic                  s_tlast     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;            // scene_start, scene_end
    logic                  m_tlast;
    logic                  cfg_wr_en   = 1'b0;
    logic [RADIUS_W-1:0]   cfg_wr_data = '0;

    // Predictor state.
    logic [DISTANCE_BITS-1:0] set_store [MAX_DISTANCES];
    int unsigned              set_count;
    int unsigned              radius;
    scene_t                   expected_scenes [$];

    // Run statistics.
    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned sets_sent;
    int unsigned scenes_checked;
    bit          pace_enable;
    int unsigned burst_left;

    scene_cut_peak_suppression_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Greedy suppression over the current set, then the scenes in ascending order.
    function automatic void predict_scenes();
        logic [MAX_DISTANCES-1:0] cut_mask;
        logic [MAX_DISTANCES-1:0] blocked;
        logic [DISTANCE_BITS-1:0] best_val;
        int                       best;
        int                       lo;
        int                       hi;
        bit                       found;
        int unsigned              prev;
        scene_t                   sc;
        cut_mask = '0;
        blocked  = '0;
        best_val = '0;
        best     = 0;
        while (1) begin
            found = 1'b0;
            for (int i = 0; i < set_count; i++) begin
                if (!(cut_mask[i] || blocked[i]) && (!found || set_store[i] > best_val)) begin
                    found    = 1'b1;
                    best     = i;
                    best_val = set_store[i];
                end
            end
            if (!found)
                break;
            cut_mask[best] = 1'b1;
            lo = (best > radius) ? best - int'(radius) : 0;
            hi = best + int'(radius);
            if (hi > int'(set_count))
                hi = set_count;
            for (int k = lo; k < hi; k++)
                blocked[k] = 1'b1;
        end
        prev = 0;
        for (int i = 0; i < set_count; i++) begin
            if (cut_mask[i]) begin
                sc.first_frame = prev[SCENE_W-1:0];
                sc.cut_pos     = SCENE_W'(i + 1);
                sc.final_scene = 1'b0;
                expected_scenes = {expected_scenes, sc};
                prev = i + 1;
            end
        end
        sc.first_frame = prev[SCENE_W-1:0];
        sc.cut_pos     = SCENE_W'(set_count + 1);
        sc.final_scene = 1'b1;
        expected_scenes = {expected_scenes, sc};
    endfunction

    // Sends one distance item and updates the predictor when it is accepted.
    task automatic send_distance(input logic [DISTANCE_BITS-1:0] dist_val, input logic last);
        int unsigned gap;
        if (pace_enable) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 16);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(dist_val);
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (set_count < MAX_DISTANCES) begin
            set_store[set_count] = dist_val;
            set_count++;
        end
        if (last) begin
            predict_scenes();
            set_count = 0;
            sets_sent++;
        end
    endtask

    // Drops valid and waits until every expected scene has come, then settles.
    task automatic wait_idle();
        int unsigned waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_scenes.size() != 0 && waited < IDLE_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // Writes the exclusion radius; only called while the core is idle.
    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        radius = value;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Reset value of the radius: a one-item set and a short set with ties.
    task automatic test_reset_radius();
        send_distance(16'h1234, 1'b1);
        send_distance(16'h0100, 1'b0);
        send_distance(16'h0300, 1'b0);
        send_distance(16'h0300, 1'b0);
        send_distance(16'h0200, 1'b0);
        send_distance(16'h0000, 1'b0);
        send_distance(16'h0300, 1'b0);
        send_distance(16'h0100, 1'b0);
        send_distance(16'h0400, 1'b1);
        wait_idle();
    endtask

    // Zero radius leaves the window empty, so every index becomes a cut.
    task automatic test_radius_zero();
        write_radius(6'd0);
        send_distance(16'h0500, 1'b0);
        send_distance(16'h0500, 1'b0);
        send_distance(16'hFFFF, 1'b0);
        send_distance(16'h0000, 1'b0);
        send_distance(16'h0500, 1'b1);
        wait_idle();
    endtask

    // Wide radii clamp at both ends, leaving a single cut.
    task automatic test_radius_wide();
        write_radius(6'd32);
        send_distance(16'h0001, 1'b0);
        send_distance(16'h0010, 1'b0);
        send_distance(16'h0100, 1'b0);
        send_distance(16'h1000, 1'b0);
        send_distance(16'h0100, 1'b0);
        send_distance(16'h0010, 1'b1);
        wait_idle();
        write_radius(6'd63);
        send_distance(16'hAAAA, 1'b0);
        send_distance(16'h5555, 1'b0);
        send_distance(16'hFFFF, 1'b0);
        send_distance(16'hFFFF, 1'b0);
        send_distance(16'h0000, 1'b1);
        wait_idle();
    endtask

    // Extreme distances with radius one.
    task automatic test_extremes();
        write_radius(6'd1);
        send_distance(16'h0000, 1'b0);
        send_distance(16'hFFFF, 1'b0);
        send_distance(16'h0000, 1'b0);
        send_distance(16'hFFFF, 1'b0);
        send_distance(16'hFFFE, 1'b1);
        wait_idle();
    endtask

    // Store full: extra distances are dropped, and a late last item still
    // starts the selection over the stored values.
    task automatic test_store_full();
        write_radius(6'd2);
        for (int i = 0; i < MAX_DISTANCES + 3; i++)
            send_distance(DISTANCE_BITS'($urandom), (i == MAX_DISTANCES + 2));
        for (int i = 0; i < MAX_DISTANCES; i++)
            send_distance(DISTANCE_BITS'($urandom_range(0, 3) << 8), (i == MAX_DISTANCES - 1));
        wait_idle();
    endtask

    // Random sets under random radii, paced in bursts.
    task automatic test_random_sets();
        int unsigned len;
        int unsigned pick;
        int unsigned since_cfg;
        logic [DISTANCE_BITS-1:0] dist_val;
        pace_enable = 1'b1;
        since_cfg   = 0;
        while (items_sent < ITEM_TARGET) begin
            if (since_cfg >= 60) begin
                // Pause until the core drains, then change the radius.
                wait_idle();
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    write_radius(RADIUS_W'($urandom_range(0, 8)));
                else
                    write_radius(RADIUS_W'($urandom_range(0, 63)));
                since_cfg = 0;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7)
                len = $urandom_range(1, 10);
            else if (pick < 9)
                len = $urandom_range(11, MAX_DISTANCES);
            else
                len = $urandom_range(MAX_DISTANCES + 1, MAX_DISTANCES + 4);
            for (int i = 0; i < len; i++) begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    dist_val = DISTANCE_BITS'($urandom);
                else if (pick < 8)
                    dist_val = DISTANCE_BITS'($urandom_range(0, 3) << 8);
                else
                    dist_val = (pick == 8) ? 16'h0000 : 16'hFFFF;
                send_distance(dist_val, (i == len - 1));
            end
            since_cfg += len;
        end
        pace_enable = 1'b0;
        wait_idle();
    endtask

    // Receiver stall pattern: modes of random length, including full rate.
    rx_mode_t    rx_mode = RX_FULL_RATE;
    int unsigned rx_left = 0;
    int unsigned rx_tick = 0;
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 120);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_FULL_RATE: m_tready <= 1'b1;
            RX_HALF:      m_tready <= $urandom_range(0, 1);
            RX_SPARSE:    m_tready <= ($urandom_range(0, 3) == 0);
            default:      m_tready <= ((rx_tick % 5) < 2);
        endcase
    end

    // Compares each accepted scene with the oldest expectation.
    always @(posedge aclk) begin
        scene_t want;
        if (aresetn && m_tvalid && m_tready) begin
            scenes_checked++;
            if (expected_scenes.size() == 0) begin
                report_mismatch("unexpected scene, start", m_tdata[5:0], -1);
            end else begin
                want = expected_scenes.pop_front();
                if (m_tdata[5:0] !== want.first_frame)
                    report_mismatch("scene_start", m_tdata[5:0], want.first_frame);
                if (m_tdata[11:6] !== want.cut_pos)
                    report_mismatch("scene_end", m_tdata[11:6], want.cut_pos);
                if (m_tlast !== want.final_scene)
                    report_mismatch("last_scene", m_tlast, want.final_scene);
            end
        end
    end

    // Hard limit on the run time.
    initial begin
        #60_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Test sequence.
    initial begin
        mismatch_count = 0;
        items_sent     = 0;
        sets_sent      = 0;
        scenes_checked = 0;
        set_count      = 0;
        radius         = RADIUS_RESET;
        pace_enable    = 1'b0;
        burst_left     = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_radius();
        test_radius_zero();
        test_radius_wide();
        test_extremes();
        test_store_full();
        test_random_sets();

        wait_idle();
        while (expected_scenes.size() != 0) begin
            report_mismatch("scene never arrived, end", 0, expected_scenes[0].cut_pos);
            void'(expected_scenes.pop_front());
        end
        $display("Sent %0d distance items in %0d sets and checked %0d scenes.",
                 items_sent, sets_sent, scenes_checked);
        $display("Radii 0 to 63, full and overflowing stores, ties and extreme distances.");
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/scps_pkg.sv
rtl/scps_front.sv
rtl/scps_job_fifo.sv
rtl/scps_back.sv
rtl/scene_cut_peak_suppression_core.sv
dv/scene_cut_peak_suppression_core_tb.sv
